### src/rrak_pkg.sv
// Package for the reduced-round cipher block: sizes, S-box and round helpers.
// Used by every module under src; depends on nothing.
`default_nettype none
package rrak_pkg;
    localparam int SLOTS = 11;
    localparam int SLOT_W = 4;
    localparam logic [1:0] REG_ROUNDS = 2'd0;
    localparam logic [1:0] REG_KSR = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [0:255];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] gdbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit word sits at bits 8i.
    function automatic logic [7:0] byt(input logic [127:0] w, input int i);
        return w[8*i +: 8];
    endfunction

    function automatic logic [127:0] ks_fwd(input logic [127:0] k);
        logic [127:0] n;
        int p;
        n = '0;
        for (int c = 0; c < 4; c++) begin
            p = 4 * ((c + 3) % 4);
            n[8*(4*c)   +: 8] = byt(k, p+1) ^ sbox(byt(k, p));
            n[8*(4*c+1) +: 8] = byt(k, p+2);
            n[8*(4*c+2) +: 8] = byt(k, p+3);
            n[8*(4*c+3) +: 8] = byt(k, p);
        end
        return n;
    endfunction

    function automatic logic [127:0] ks_bwd(input logic [127:0] k);
        logic [127:0] n;
        int q;
        n = '0;
        for (int c = 0; c < 4; c++) begin
            q = 4 * ((c + 1) % 4);
            n[8*(4*c)   +: 8] = byt(k, q+3);
            n[8*(4*c+1) +: 8] = byt(k, q) ^ sbox(byt(k, q+3));
            n[8*(4*c+2) +: 8] = byt(k, q+1);
            n[8*(4*c+3) +: 8] = byt(k, q+2);
        end
        return n;
    endfunction

    // Map a key state to the round key it represents.
    function automatic logic [127:0] to_rk(input logic [127:0] s);
        logic [127:0] r;
        r[7:0]     = byt(s,3) ^ byt(s,6) ^ byt(s,9) ^ byt(s,12);
        r[15:8]    = byt(s,2) ^ byt(s,5) ^ byt(s,8) ^ byt(s,15);
        r[23:16]   = byt(s,1) ^ byt(s,4) ^ byt(s,11) ^ byt(s,14);
        r[31:24]   = byt(s,0) ^ byt(s,7) ^ byt(s,10) ^ byt(s,13);
        r[39:32]   = byt(s,6) ^ byt(s,12);
        r[47:40]   = byt(s,2) ^ byt(s,8);
        r[55:48]   = byt(s,4) ^ byt(s,14);
        r[63:56]   = byt(s,0) ^ byt(s,10);
        r[71:64]   = byt(s,3) ^ byt(s,12);
        r[79:72]   = byt(s,8) ^ byt(s,15);
        r[87:80]   = byt(s,4) ^ byt(s,11);
        r[95:88]   = byt(s,0) ^ byt(s,7);
        r[103:96]  = byt(s,12);
        r[111:104] = byt(s,8);
        r[119:112] = byt(s,4);
        r[127:120] = byt(s,0);
        return r;
    endfunction

    function automatic logic [127:0] full_round(input logic [127:0] st);
        logic [127:0] t, o;
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[8*(r+4*c) +: 8] = sbox(byt(st, r + 4*((c + r) % 4)));
        for (int c = 0; c < 4; c++) begin
            a0 = byt(t,4*c); a1 = byt(t,4*c+1); a2 = byt(t,4*c+2); a3 = byt(t,4*c+3);
            d0 = gdbl(a0); d1 = gdbl(a1); d2 = gdbl(a2); d3 = gdbl(a3);
            o[8*(4*c)   +: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
            o[8*(4*c+1) +: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
            o[8*(4*c+2) +: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
            o[8*(4*c+3) +: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
        end
        return o;
    endfunction
endpackage
`default_nettype wire

### src/rrak_keymem.sv
// Round-key store: 11 x 128-bit synchronous memory with a registered read port.
// Valid bits make unwritten slots read as zero after reset. Uses rrak_pkg.
`default_nettype none
module rrak_keymem (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_we,
    input  wire logic [rrak_pkg::SLOT_W-1:0] i_waddr,
    input  wire logic [127:0]                i_wdata,
    input  wire logic [rrak_pkg::SLOT_W-1:0] i_raddr,
    output logic      [127:0]                o_rdata
);
    import rrak_pkg::*;
    logic [127:0] mem [0:SLOTS-1];
    logic [SLOTS-1:0] r_vld;
    logic [127:0] r_data;
    logic r_rv;

    // Write port and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we && i_waddr < SLOT_W'(SLOTS)) begin
            r_vld[i_waddr] <= 1'b1;
        end
        if (i_we && i_waddr < SLOT_W'(SLOTS)) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; slots beyond the store or never written give zero.
    always_ff @(posedge i_clk) begin
        if (i_raddr < SLOT_W'(SLOTS)) begin
            r_data <= mem[i_raddr];
            r_rv   <= r_vld[i_raddr];
        end else begin
            r_data <= '0;
            r_rv   <= 1'b0;
        end
    end
    assign o_rdata = r_rv ? r_data : '0;
endmodule
`default_nettype wire

### src/reduced_round_aes_from_key_state.sv
// Reduced-round AES block: key walk into the round-key store, then the cipher.
// One item at a time: start is accepted only in the idle state.
// busy is high from acceptance until the result strobe; result lasts one cycle.
// Synchronous active-low reset clears the store valid bits and loads register defaults.
`default_nettype none
module reduced_round_aes_from_key_state (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_key_lo,
    input  wire logic [63:0] i_key_hi,
    input  wire logic [63:0] i_plain_lo,
    input  wire logic [63:0] i_plain_hi,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data,
    output logic             o_valid,
    output logic [63:0]      o_cipher_lo,
    output logic [63:0]      o_cipher_hi
);
    import rrak_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0, S_BWD = 3'd1, S_FWD = 3'd2, S_RD0 = 3'd3,
                           S_RND = 3'd4, S_DONE = 3'd5;

    logic [2:0]   r_st;
    logic [3:0]   r_rounds, r_ksr, r_limit, r_k;
    logic [127:0] r_key, r_cur, r_pt;
    logic         we;
    logic [3:0]   waddr, raddr;
    logic [127:0] wdata, rdata;

    rrak_keymem u_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign busy = (r_st != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Store write: backward and forward walk steps.
    always_comb begin
        we = 1'b0;
        waddr = r_k;
        wdata = to_rk(r_cur);
        if (r_st == S_BWD) begin
            we = 1'b1;
        end else if (r_st == S_FWD) begin
            we = 1'b1;
            wdata = to_rk(ks_fwd(r_cur));
        end
    end

    // Read address: slot 0 for whitening, then slot k+1 during rounds.
    always_comb begin
        raddr = 4'd0;
        if (r_st == S_RND) raddr = r_k + 4'd1;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rounds <= 4'd4;
            r_ksr    <= 4'd2;
            r_limit  <= 4'd5;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROUNDS: r_rounds <= i_cfg_data;
                REG_KSR:    r_ksr    <= i_cfg_data;
                REG_LIMIT:  r_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer. In S_RND, r_k counts rounds done; rdata holds key slot r_k.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (start) begin
                    r_key <= {i_key_hi, i_key_lo};
                    r_cur <= {i_key_hi, i_key_lo};
                    r_pt  <= {i_plain_hi, i_plain_lo};
                    r_k   <= r_ksr;
                    r_st  <= S_BWD;
                end
                S_BWD: begin
                    if (r_k == 4'd0) begin
                        r_cur <= r_key;
                        r_k   <= r_ksr + 4'd1;
                        r_st  <= ({1'b0, r_ksr} + 5'd1 < {1'b0, r_limit}) ? S_FWD : S_RD0;
                    end else begin
                        r_cur <= ks_bwd(r_cur);
                        r_k   <= r_k - 4'd1;
                    end
                end
                S_FWD: begin
                    r_cur <= ks_fwd(r_cur);
                    r_k   <= r_k + 4'd1;
                    if (r_k + 4'd1 >= r_limit) r_st <= S_RD0;
                end
                S_RD0: begin
                    r_k  <= 4'd0;
                    r_st <= S_RND;
                end
                S_RND: begin
                    if (r_k == 4'd0) r_pt <= r_pt ^ rdata;
                    else r_pt <= full_round(r_pt) ^ rdata;
                    r_k <= r_k + 4'd1;
                    if (r_k == r_rounds) r_st <= S_DONE;
                end
                S_DONE: begin
                    o_valid     <= 1'b1;
                    o_cipher_lo <= r_pt[63:0];
                    o_cipher_hi <= r_pt[127:64];
                    r_st        <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
